// ===== rtl/box_blur_clamped_edges_core_assert.svh =====
// Assertion macros for the checker file.
`ifndef BOX_BLUR_CLAMPED_EDGES_CORE_ASSERT_SVH
`define BOX_BLUR_CLAMPED_EDGES_CORE_ASSERT_SVH

// Checked at every edge outside reset.
`define BBCE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define BBCE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/bbce_pkg.sv =====
package bbce_pkg;

    localparam int PIX_W      = 8;
    localparam int NCH        = 4;
    localparam int ROW_W      = 16;
    localparam int COL_W      = 12;
    localparam int WIDTH_W    = 13;
    localparam int HEIGHT_W   = 16;
    localparam int CHAN_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST    = 13'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST   = 16'd480;
    localparam logic [CHAN_W-1:0]   CHANNELS_RST = 3'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH    = 2'd0,
        CFG_HEIGHT   = 2'd1,
        CFG_CHANNELS = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_DRAIN = 1'b1
    } req_t;

endpackage

// ===== rtl/bbce_pix_if.sv =====
interface bbce_pix_if;
    logic                        valid;
    logic                        ready;
    bbce_pkg::req_t              req_type;
    logic [bbce_pkg::PIX_W-1:0]  pixel_c0;
    logic [bbce_pkg::PIX_W-1:0]  pixel_c1;
    logic [bbce_pkg::PIX_W-1:0]  pixel_c2;
    logic [bbce_pkg::PIX_W-1:0]  pixel_c3;

    modport source (output valid, req_type, pixel_c0, pixel_c1, pixel_c2, pixel_c3,
                    input ready);
    modport sink   (input valid, req_type, pixel_c0, pixel_c1, pixel_c2, pixel_c3,
                    output ready);
endinterface

// ===== rtl/bbce_res_if.sv =====
interface bbce_res_if;
    logic                        valid;
    logic                        ready;
    logic [bbce_pkg::PIX_W-1:0]  out_c0;
    logic [bbce_pkg::PIX_W-1:0]  out_c1;
    logic [bbce_pkg::PIX_W-1:0]  out_c2;
    logic [bbce_pkg::PIX_W-1:0]  out_c3;
    logic [bbce_pkg::ROW_W-1:0]  out_row;
    logic [bbce_pkg::COL_W-1:0]  out_col;
    logic                        run_last;
    logic                        image_last;

    modport source (output valid, out_c0, out_c1, out_c2, out_c3, out_row, out_col,
                    run_last, image_last, input ready);
    modport sink   (input valid, out_c0, out_c1, out_c2, out_c3, out_row, out_col,
                    run_last, image_last, output ready);
endinterface

// ===== rtl/bbce_cfg_if.sv =====
interface bbce_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bbce_pkg::CFG_IDX_W-1:0]   index;
    logic [bbce_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/box_blur_clamped_edges_core.sv =====
// Streaming (2R+1)x(2R+1) box mean with edge replication, 1..4 8-bit channels.
// Pixels come in raster order, then R rows of drain items stand in for the
// replicated bottom row. One item is taken per clock unless intake is held.
// An item releases no result, one result, or min(W, R+1) results at a row
// end; the result stage hands out one result per clock unless stalled, so a
// row-end burst holds intake until its last result leaves that stage.
// Results pass the column-sum, window-sum and divide stages in turn. Rows
// live in 2R+1 line banks (one read port each, registered read); column
// sums are formed once per column and kept in a small history of the last
// 2R+1 columns. Any register write restarts the image; a write to an
// unknown index is taken and ignored. Reads of never-written line entries
// only occur outside the legal use, so there is no clearing pass after reset.
module box_blur_clamped_edges_core #(
    parameter int RADIUS    = 3,
    parameter int MAX_WIDTH = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    bbce_pix_if.sink    pix,
    bbce_res_if.source  res,
    bbce_cfg_if.sink    cfg
);

    localparam int NCH     = bbce_pkg::NCH;
    localparam int PIX_W   = bbce_pkg::PIX_W;
    localparam int WIN     = 2 * RADIUS + 1;
    localparam int XW      = $clog2(MAX_WIDTH);
    localparam int SW      = $clog2(WIN);
    localparam int YW      = bbce_pkg::ROW_W + 1;
    localparam int DW      = $clog2(RADIUS + 1);
    localparam int VW      = $clog2(WIN * 255 + 1);
    localparam int HW      = $clog2(WIN * WIN * 255 + 1);
    localparam int DIVISOR = WIN * WIN;
    localparam int KSH     = HW + 8;
    localparam int MULT    = (2 ** KSH) / DIVISOR;
    localparam int PW      = KSH + HW;
    localparam int MEM_W   = NCH * PIX_W;

    // ---------------- configuration ----------------
    logic [bbce_pkg::WIDTH_W-1:0]  width_reg;
    logic [bbce_pkg::HEIGHT_W-1:0] height_reg;
    logic [bbce_pkg::CHAN_W-1:0]   chan_reg;
    logic                          cfg_we;

    assign cfg.ready = 1'b1;
    // only a known register index restarts the image
    assign cfg_we    = cfg.valid && (cfg.index inside {bbce_pkg::CFG_WIDTH,
                                                       bbce_pkg::CFG_HEIGHT,
                                                       bbce_pkg::CFG_CHANNELS});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bbce_pkg::WIDTH_RST;
            height_reg <= bbce_pkg::HEIGHT_RST;
            chan_reg   <= bbce_pkg::CHANNELS_RST;
        end
        else if (cfg_we)
        begin
            case (bbce_pkg::cfg_idx_t'(cfg.index))
                bbce_pkg::CFG_WIDTH:    width_reg  <= cfg.data[bbce_pkg::WIDTH_W-1:0];
                bbce_pkg::CFG_HEIGHT:   height_reg <= cfg.data[bbce_pkg::HEIGHT_W-1:0];
                bbce_pkg::CFG_CHANNELS: chan_reg   <= cfg.data[bbce_pkg::CHAN_W-1:0];
                default:                ;
            endcase
        end
    end

    // effective values: out-of-range registers are clamped
    logic [XW-1:0]                 wm1;
    logic [bbce_pkg::HEIGHT_W-1:0] h_eff;
    logic [bbce_pkg::CHAN_W-1:0]   nch_eff;

    always_comb
    begin
        if (width_reg == '0)
            wm1 = '0;
        else if (int'(width_reg) > MAX_WIDTH)
            wm1 = XW'(MAX_WIDTH - 1);
        else
            wm1 = XW'(width_reg - 1'b1);
        h_eff = (height_reg == '0) ? bbce_pkg::HEIGHT_W'(1) : height_reg;
        if (chan_reg == '0)
            nch_eff = bbce_pkg::CHAN_W'(1);
        else if (chan_reg > bbce_pkg::CHAN_W'(NCH))
            nch_eff = bbce_pkg::CHAN_W'(NCH);
        else
            nch_eff = chan_reg;
    end

    // ---------------- intake (stage 0) ----------------
    logic [YW-1:0] y_reg;
    logic [XW-1:0] x_reg;
    logic [SW-1:0] slot_reg;       // y_reg mod WIN
    logic [SW-1:0] slot_last_reg;  // bank holding the bottom row

    logic          real_row, kind_ok, acc, go, row_end, wrap, emit0, lastrow0;
    logic [YW-1:0] h_ext;
    logic [DW-1:0] d0;
    logic [SW-1:0] sel0 [WIN];
    logic          sub0 [WIN];
    logic [MEM_W-1:0] pixw;

    assign h_ext    = YW'(h_eff);
    assign real_row = y_reg < h_ext;
    assign kind_ok  = real_row ? (pix.req_type == bbce_pkg::REQ_PIXEL)
                               : (pix.req_type == bbce_pkg::REQ_DRAIN);
    assign acc      = pix.valid && pix.ready;
    assign go       = acc && kind_ok;
    assign row_end  = x_reg == wm1;
    assign wrap     = (y_reg + 1'b1) >= (h_ext + YW'(RADIUS));
    assign pixw     = {pix.pixel_c3, pix.pixel_c2, pix.pixel_c1, pix.pixel_c0};
    assign emit0    = (y_reg >= YW'(RADIUS)) && (row_end || x_reg >= XW'(RADIUS));
    assign lastrow0 = y_reg == (h_ext - 1'b1 + YW'(RADIUS));
    assign d0       = (row_end && x_reg < XW'(RADIUS)) ? DW'(x_reg) : DW'(RADIUS);

    // bank for each vertical tap k (row y-2R+k, clamped to the image)
    always_comb
    begin
        logic [SW:0] tmp;
        for (int k = 0; k < WIN; k++)
        begin
            tmp = (SW+1)'(slot_reg) + (SW+1)'(k + 1);
            if (tmp >= (SW+1)'(WIN))
                tmp = tmp - (SW+1)'(WIN);
            if (y_reg + YW'(k) < YW'(2 * RADIUS))
                sel0[k] = '0;
            else if (y_reg + YW'(k) >= h_ext + YW'(2 * RADIUS))
                sel0[k] = slot_last_reg;
            else
                sel0[k] = tmp[SW-1:0];
            // the bank being written this cycle reads stale: use the pixel
            sub0[k] = real_row && (sel0[k] == slot_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_reg         <= '0;
            x_reg         <= '0;
            slot_reg      <= '0;
            slot_last_reg <= '0;
        end
        else if (cfg_we)
        begin
            y_reg    <= '0;
            x_reg    <= '0;
            slot_reg <= '0;
        end
        else if (go)
        begin
            if (row_end)
            begin
                x_reg <= '0;
                if (real_row && y_reg == h_ext - 1'b1)
                    slot_last_reg <= slot_reg;
                if (wrap)
                begin
                    y_reg    <= '0;
                    slot_reg <= '0;
                end
                else
                begin
                    y_reg    <= y_reg + 1'b1;
                    slot_reg <= (slot_reg == SW'(WIN - 1)) ? '0 : slot_reg + 1'b1;
                end
            end
            else
            begin
                x_reg <= x_reg + 1'b1;
            end
        end
    end

    // ---------------- line banks ----------------
    logic [MEM_W-1:0] line_mem [WIN][MAX_WIDTH];
    logic [MEM_W-1:0] rd1_reg  [WIN];

    always_ff @(posedge clk)
    begin
        if (go && real_row)
            line_mem[slot_reg][x_reg] <= pixw;
        if (go)
            for (int b = 0; b < WIN; b++)
                rd1_reg[b] <= line_mem[b][x_reg];
    end

    // ---------------- pipeline handshake ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy3, rdy4, rdy5, fire, p2_done, p2_free, p1_move;

    logic          rowend2_reg;
    logic [DW-1:0] d2_reg;

    assign rdy5    = !v5_reg || res.ready;
    assign rdy4    = !v4_reg || rdy5;
    assign rdy3    = !v3_reg || rdy4;
    assign fire    = v2_reg && rdy3;
    assign p2_done = !rowend2_reg || d2_reg == '0;
    assign p2_free = !v2_reg || (fire && p2_done);
    assign p1_move = v1_reg && p2_free;
    assign pix.ready = !v1_reg || p1_move;

    // ---------------- stage 1: column sum ----------------
    logic [SW-1:0]    sel1_reg [WIN];
    logic             sub1_reg [WIN];
    logic [MEM_W-1:0] pix1_reg;
    logic             emit1_reg, rowend1_reg, lastrow1_reg;
    logic [XW-1:0]    x1_reg;
    logic [bbce_pkg::ROW_W-1:0] r1_reg;
    logic [DW-1:0]    d1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (go)
            v1_reg <= 1'b1;
        else if (p1_move)
            v1_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            sel1_reg     <= sel0;
            sub1_reg     <= sub0;
            pix1_reg     <= pixw;
            emit1_reg    <= emit0;
            rowend1_reg  <= row_end;
            lastrow1_reg <= lastrow0;
            x1_reg       <= x_reg;
            r1_reg       <= bbce_pkg::ROW_W'(y_reg - YW'(RADIUS));
            d1_reg       <= d0;
        end
    end

    logic [NCH-1:0][VW-1:0] vsum1;

    always_comb
    begin
        logic [MEM_W-1:0] t;
        for (int ch = 0; ch < NCH; ch++)
            vsum1[ch] = '0;
        for (int k = 0; k < WIN; k++)
        begin
            t = sub1_reg[k] ? pix1_reg : rd1_reg[sel1_reg[k]];
            for (int ch = 0; ch < NCH; ch++)
                vsum1[ch] = vsum1[ch] + VW'(t[ch*PIX_W +: PIX_W]);
        end
    end

    // column-sum history: hist[i] is the sum of column x-i
    logic [NCH-1:0][VW-1:0] hist_reg [WIN];
    logic [NCH-1:0][VW-1:0] vsum0_reg;

    always_ff @(posedge clk)
    begin
        if (p1_move)
        begin
            hist_reg[0] <= vsum1;
            for (int i = 1; i < WIN; i++)
                hist_reg[i] <= hist_reg[i-1];
            if (x1_reg == '0)
                vsum0_reg <= vsum1;
        end
    end

    // -------- stage 2: window sums, one result per cycle unless stalled --------
    logic          lastrow2_reg;
    logic [XW-1:0] x2_reg;
    logic [bbce_pkg::ROW_W-1:0] r2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            d2_reg <= '0;
        end
        else if (p1_move)
        begin
            v2_reg <= emit1_reg;
            d2_reg <= d1_reg;
        end
        else if (fire)
        begin
            if (p2_done)
                v2_reg <= 1'b0;
            else
                d2_reg <= d2_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_move)
        begin
            rowend2_reg  <= rowend1_reg;
            lastrow2_reg <= lastrow1_reg;
            x2_reg       <= x1_reg;
            r2_reg       <= r1_reg;
        end
    end

    logic [NCH-1:0][HW-1:0] hsum2;
    logic [SW-1:0]          a2;

    assign a2 = SW'(d2_reg) + SW'(RADIUS);

    // tap k covers column c-R+k; left of the image uses column 0,
    // right of the image uses the row's last column
    always_comb
    begin
        logic [NCH-1:0][VW-1:0] t;
        logic [SW-1:0]          i;
        for (int ch = 0; ch < NCH; ch++)
            hsum2[ch] = '0;
        for (int k = 0; k < WIN; k++)
        begin
            i = a2 - SW'(k);
            if (a2 < SW'(k))
                t = hist_reg[0];
            else if (XW'(i) > x2_reg)
                t = vsum0_reg;
            else
                t = hist_reg[i];
            for (int ch = 0; ch < NCH; ch++)
                hsum2[ch] = hsum2[ch] + HW'(t[ch]);
        end
        for (int ch = 0; ch < NCH; ch++)
            if (bbce_pkg::CHAN_W'(ch) >= nch_eff)
                hsum2[ch] = '0;
    end

    // ---------------- stages 3..5: divide by window area ----------------
    logic [NCH-1:0][HW-1:0]    s3_reg, s4_reg;
    logic [NCH-1:0][PIX_W-1:0] q4_reg, q5_reg;
    logic [bbce_pkg::ROW_W-1:0] r3_reg, r4_reg, r5_reg;
    logic [bbce_pkg::COL_W-1:0] c3_reg, c4_reg, c5_reg;
    logic rl3_reg, rl4_reg, rl5_reg, il3_reg, il4_reg, il5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy3)
                v3_reg <= fire;
            if (rdy4)
                v4_reg <= v3_reg;
            if (rdy5)
                v5_reg <= v4_reg;
        end
    end

    logic [NCH-1:0][PW-1:0]    prod3;
    logic [NCH-1:0][HW-1:0]    rem4;
    logic [NCH-1:0][PIX_W-1:0] q5_next;

    always_comb
    begin
        for (int ch = 0; ch < NCH; ch++)
        begin
            prod3[ch]   = PW'(s3_reg[ch]) * PW'(MULT);
            rem4[ch]    = s4_reg[ch] - HW'(q4_reg[ch]) * HW'(DIVISOR);
            q5_next[ch] = q4_reg[ch] + PIX_W'(rem4[ch] >= HW'(DIVISOR));
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && rdy3)
        begin
            s3_reg  <= hsum2;
            r3_reg  <= r2_reg;
            c3_reg  <= bbce_pkg::COL_W'(x2_reg - XW'(d2_reg));
            rl3_reg <= p2_done;
            il3_reg <= rowend2_reg && d2_reg == '0 && lastrow2_reg;
        end
        if (rdy4)
        begin
            s4_reg  <= s3_reg;
            for (int ch = 0; ch < NCH; ch++)
                q4_reg[ch] <= prod3[ch][KSH +: PIX_W];
            r4_reg  <= r3_reg;
            c4_reg  <= c3_reg;
            rl4_reg <= rl3_reg;
            il4_reg <= il3_reg;
        end
        if (rdy5)
        begin
            q5_reg  <= q5_next;
            r5_reg  <= r4_reg;
            c5_reg  <= c4_reg;
            rl5_reg <= rl4_reg;
            il5_reg <= il4_reg;
        end
    end

    assign res.valid      = v5_reg;
    assign res.out_c0     = q5_reg[0];
    assign res.out_c1     = q5_reg[1];
    assign res.out_c2     = q5_reg[2];
    assign res.out_c3     = q5_reg[3];
    assign res.out_row    = r5_reg;
    assign res.out_col    = c5_reg;
    assign res.run_last   = rl5_reg;
    assign res.image_last = il5_reg;

endmodule

// ===== rtl/bbce_checker.sv =====
`include "box_blur_clamped_edges_core_assert.svh"

module bbce_checker (
    input logic clk,
    input logic rst_n,
    input logic res_valid,
    input logic res_ready,
    input logic run_last,
    input logic image_last
);

    // a waiting result is not withdrawn
    `BBCE_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid, "result dropped under stall")

    // the image's final pixel always closes its item's run
    `BBCE_ASSERT(a_img_run, res_valid && image_last |-> run_last, "image_last without run_last")

    // reset leaves no result pending
    `BBCE_ASSERT_ALWAYS(a_rst_empty, !rst_n |-> !res_valid, "result valid in reset")

endmodule

bind box_blur_clamped_edges_core bbce_checker u_bbce_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .run_last   (res.run_last),
    .image_last (res.image_last)
);

// ===== tb/box_blur_clamped_edges_core_test.sv =====
module box_blur_clamped_edges_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAD      = 3;
    localparam int SPAN     = 2 * RAD + 1;
    localparam int MAXW     = 4096;
    localparam int PXW      = bbce_pkg::PIX_W;
    localparam int NCHN     = bbce_pkg::NCH;
    localparam int DATA_W   = bbce_pkg::CFG_DATA_W;
    // a few hundred small-image items plus stalls; far above any correct run
    localparam int LIMIT    = 900000;
    // results trail their item through the pipeline; leave margin before touching registers
    localparam int SETTLE   = 12;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    bbce_pix_if pix ();
    bbce_res_if res ();
    bbce_cfg_if cfg ();

    box_blur_clamped_edges_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix),
        .res   (res),
        .cfg   (cfg)
    );

    // One expected output pixel.
    typedef struct {
        logic [PXW-1:0]                 ch [NCHN];
        logic [bbce_pkg::ROW_W-1:0]     row;
        logic [bbce_pkg::COL_W-1:0]     col;
        logic                           run_last;
        logic                           image_last;
    } blur_pixel_t;

    blur_pixel_t pending_pixels [$];

    // Predictor state: line rows, stream position and register copies.
    logic [PXW-1:0]                   row_buf [SPAN][MAXW][NCHN];
    int unsigned                      in_row;
    int unsigned                      in_col;
    logic [bbce_pkg::WIDTH_W-1:0]     width_reg;
    logic [bbce_pkg::HEIGHT_W-1:0]    height_reg;
    logic [bbce_pkg::CHAN_W-1:0]      chan_reg;

    int fail_count = 0;
    int items_sent = 0;
    int unsigned cycles = 0;

    // Idling controls for the two sides.
    logic calm = 1'b0;       // no random idling at all
    logic res_hold = 1'b0;   // receiver held off

    function automatic int unsigned eff_w();
        if (width_reg < 1) return 1;
        if (width_reg > MAXW) return MAXW;
        return width_reg;
    endfunction

    function automatic int unsigned eff_h();
        return (height_reg < 1) ? 1 : height_reg;
    endfunction

    function automatic int unsigned eff_ch();
        if (chan_reg < 1) return 1;
        if (chan_reg > 4) return 4;
        return chan_reg;
    endfunction

    function automatic int clampi(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Box mean of output pixel (r, c) over the replicated-edge window.
    function automatic blur_pixel_t window_mean(int r, int c);
        blur_pixel_t p;
        int unsigned w;
        int unsigned h;
        int unsigned sum;
        int ry;
        int cx;
        w = eff_w();
        h = eff_h();
        for (int k = 0; k < NCHN; k++) begin
            sum = 0;
            if (k < eff_ch()) begin
                for (int dy = -RAD; dy <= RAD; dy++) begin
                    ry = clampi(r + dy, 0, h - 1);
                    for (int dx = -RAD; dx <= RAD; dx++) begin
                        cx = clampi(c + dx, 0, w - 1);
                        sum += row_buf[ry % SPAN][cx][k];
                    end
                end
                sum = sum / (SPAN * SPAN);
            end
            p.ch[k] = sum[PXW-1:0];
        end
        p.row = r[bbce_pkg::ROW_W-1:0];
        p.col = c[bbce_pkg::COL_W-1:0];
        p.run_last = 1'b0;
        p.image_last = (r == h - 1 && c == w - 1);
        return p;
    endfunction

    // Advance the stream by one accepted item and queue what it releases.
    task automatic blur_predict(bbce_pkg::req_t kind, logic [PXW-1:0] s [NCHN]);
        int unsigned w;
        int unsigned h;
        int unsigned lo;
        int unsigned hi;
        logic is_real;
        logic any;
        blur_pixel_t p;
        w = eff_w();
        h = eff_h();
        is_real = (in_row < h);
        // wrong kind for this phase: dropped, no state change
        if ((kind == bbce_pkg::REQ_DRAIN) == is_real)
            return;
        if (is_real)
            for (int k = 0; k < NCHN; k++)
                row_buf[in_row % SPAN][in_col][k] = s[k];
        if (in_row >= RAD) begin
            any = 1'b1;
            if (in_col == w - 1) begin
                lo = (in_col >= RAD) ? in_col - RAD : 0;
                hi = in_col;
            end else if (in_col >= RAD) begin
                lo = in_col - RAD;
                hi = lo;
            end else begin
                lo = 0;
                hi = 0;
                any = 1'b0;
            end
            if (any)
                for (int unsigned c = lo; c <= hi; c++) begin
                    p = window_mean(in_row - RAD, c);
                    p.run_last = (c == hi);
                    pending_pixels.push_back(p);
                end
        end
        if (in_col + 1 >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= h + RAD)
                in_row = 0;
        end else begin
            in_col++;
        end
    endtask

    task automatic report(string what, int got, int want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge clk) begin
        blur_pixel_t e;
        if (rst_n && res.valid && res.ready) begin
            if (pending_pixels.size() == 0) begin
                report("unexpected result row", int'(res.out_row), -1);
            end else begin
                e = pending_pixels.pop_front();
                if (res.out_c0 !== e.ch[0])
                    report("out_c0", int'(res.out_c0), int'(e.ch[0]));
                if (res.out_c1 !== e.ch[1])
                    report("out_c1", int'(res.out_c1), int'(e.ch[1]));
                if (res.out_c2 !== e.ch[2])
                    report("out_c2", int'(res.out_c2), int'(e.ch[2]));
                if (res.out_c3 !== e.ch[3])
                    report("out_c3", int'(res.out_c3), int'(e.ch[3]));
                if (res.out_row !== e.row)
                    report("out_row", int'(res.out_row), int'(e.row));
                if (res.out_col !== e.col)
                    report("out_col", int'(res.out_col), int'(e.col));
                if (res.run_last !== e.run_last)
                    report("run_last", int'(res.run_last), int'(e.run_last));
                if (res.image_last !== e.image_last)
                    report("image_last", int'(res.image_last), int'(e.image_last));
            end
        end
    end

    // Receiver: random stalls unless calm, fully off while held.
    always @(posedge clk) begin
        if (res_hold)
            res.ready <= 1'b0;
        else if (calm)
            res.ready <= 1'b1;
        else
            res.ready <= ($urandom_range(99) >= 26);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("box_blur_clamped_edges_core test failed");
            $finish;
        end
    end

    function automatic logic [PXW-1:0] rand_sample();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hff;
            default: return PXW'($urandom_range(255));
        endcase
    endfunction

    // Offer one item; returns at the edge that accepted it.
    // A single idle cycle before about a third of the items keeps the
    // sender idle in about a quarter of its cycles.
    task automatic send_item(bbce_pkg::req_t kind, logic [PXW-1:0] s [NCHN]);
        if (!calm && $urandom_range(99) < 35) begin
            pix.valid <= 1'b0;
            @(posedge clk);
        end
        pix.valid    <= 1'b1;
        pix.req_type <= kind;
        pix.pixel_c0 <= s[0];
        pix.pixel_c1 <= s[1];
        pix.pixel_c2 <= s[2];
        pix.pixel_c3 <= s[3];
        @(posedge clk);
        while (!pix.ready) @(posedge clk);
        items_sent++;
        blur_predict(kind, s);
    endtask

    task automatic send_random(bbce_pkg::req_t kind);
        logic [PXW-1:0] s [NCHN];
        for (int k = 0; k < NCHN; k++) s[k] = rand_sample();
        send_item(kind, s);
    endtask

    // Sender pause until every expected result is in, then let the pipe empty.
    task automatic wait_drained();
        pix.valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(bbce_pkg::cfg_idx_t idx, logic [DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
        case (idx)
            bbce_pkg::CFG_WIDTH:    width_reg  = value[bbce_pkg::WIDTH_W-1:0];
            bbce_pkg::CFG_HEIGHT:   height_reg = value[bbce_pkg::HEIGHT_W-1:0];
            bbce_pkg::CFG_CHANNELS: chan_reg   = value[bbce_pkg::CHAN_W-1:0];
            default: ;
        endcase
        in_row = 0;
        in_col = 0;
    endtask

    task automatic configure(int w, int h, int ch);
        wait_drained();
        write_reg(bbce_pkg::CFG_WIDTH, DATA_W'(w));
        write_reg(bbce_pkg::CFG_HEIGHT, DATA_W'(h));
        write_reg(bbce_pkg::CFG_CHANNELS, DATA_W'(ch));
    endtask

    // Whole image plus drain rows; noise_pct adds items of the wrong kind.
    task automatic stream_image(int noise_pct, int row_cap = -1);
        int rows;
        bbce_pkg::req_t kind;
        rows = eff_h() + RAD;
        if (row_cap >= 0 && row_cap < rows) rows = row_cap;
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < eff_w(); c++) begin
                kind = (r < eff_h()) ? bbce_pkg::REQ_PIXEL : bbce_pkg::REQ_DRAIN;
                if ($urandom_range(99) < noise_pct)
                    send_random(kind == bbce_pkg::REQ_PIXEL ? bbce_pkg::REQ_DRAIN
                                                            : bbce_pkg::REQ_PIXEL);
                send_random(kind);
            end
    endtask

    // Zero registers act as one: a single pixel and three drain rows, then a two-pixel row.
    task automatic test_degenerate_sizes();
        logic [PXW-1:0] s [NCHN];
        configure(0, 0, 0);
        s = '{8'hff, 8'h00, 8'hff, 8'h00};
        send_item(bbce_pkg::REQ_PIXEL, s);
        for (int i = 0; i < RAD; i++) send_random(bbce_pkg::REQ_DRAIN);
        configure(2, 1, 4);
        s = '{8'h00, 8'hff, 8'h00, 8'hff};
        send_item(bbce_pkg::REQ_PIXEL, s);
        s = '{8'hff, 8'hff, 8'hff, 8'hff};
        send_item(bbce_pkg::REQ_PIXEL, s);
        stream_image(0, 0);
        for (int i = 0; i < 2 * RAD; i++) send_random(bbce_pkg::REQ_DRAIN);
    endtask

    // Drain items during real rows and pixels during drain rows are dropped.
    task automatic test_wrong_kind();
        configure(4, 2, 2);
        stream_image(40);
    endtask

    // Channel count above four clamps to four; odd channel counts from one to seven in turn.
    task automatic test_channel_counts();
        for (int ch = 1; ch <= 7; ch += 2) begin
            configure(5, 2, ch);
            stream_image(0);
        end
    endtask

    // A register write in the middle of an image restarts it.
    task automatic test_restart();
        configure(3, 16'hffff, 3);
        stream_image(0, 5);
        configure(6, 3, 4);
        stream_image(0, 2);
        configure(6, 3, 4);
        stream_image(0);
    endtask

    // Width above the store size is taken; the start of its first row
    // releases nothing.
    task automatic test_widest_row();
        configure(13'h1fff, 1, 4);
        for (int i = 0; i < 16; i++) send_random(bbce_pkg::REQ_PIXEL);
    endtask

    // Receiver held off long while the sender keeps offering: the block fills.
    task automatic test_back_pressure();
        configure(9, 4, 4);
        res_hold <= 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                res_hold <= 1'b0;
            end
        join_none
        stream_image(0);
        wait_drained();
    endtask

    // Random small images, mostly clean, some noisy and some cut short.
    task automatic test_random_images();
        int start;
        start = items_sent;
        while (items_sent - start < 130) begin
            calm = (items_sent - start < 50);
            configure($urandom_range(1, 10), $urandom_range(1, 7), $urandom_range(0, 7));
            case ($urandom_range(9))
                0: stream_image(10);
                1: stream_image(0, $urandom_range(1, 4));
                default: stream_image(0);
            endcase
        end
        calm = 1'b0;
    endtask

    initial begin
        pix.valid = 1'b0;
        pix.req_type = bbce_pkg::REQ_PIXEL;
        pix.pixel_c0 = '0;
        pix.pixel_c1 = '0;
        pix.pixel_c2 = '0;
        pix.pixel_c3 = '0;
        res.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = bbce_pkg::CFG_WIDTH;
        cfg.data = '0;
        width_reg = bbce_pkg::WIDTH_RST;
        height_reg = bbce_pkg::HEIGHT_RST;
        chan_reg = bbce_pkg::CHANNELS_RST;
        in_row = 0;
        in_col = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_degenerate_sizes();
        test_wrong_kind();
        test_channel_counts();
        test_restart();
        test_back_pressure();
        test_random_images();
        test_widest_row();

        wait_drained();
        if (fail_count == 0)
            $display("box_blur_clamped_edges_core test passed");
        else
            $display("box_blur_clamped_edges_core test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bbce_pkg.sv
rtl/bbce_pix_if.sv
rtl/bbce_res_if.sv
rtl/bbce_cfg_if.sv
rtl/box_blur_clamped_edges_core.sv
rtl/bbce_checker.sv
tb/box_blur_clamped_edges_core_test.sv
